// ===== design/mbps_pkg.sv =====
// ----------------------------------------------------------------------------
// mbps_pkg: shared types and constants for the masked byte pattern scanner
// Beat payloads, the compare configuration bundle and register indexes.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int MAX_PATTERN = 32;   // window depth plus the current byte
  localparam int COUNT_BITS  = 32;   // width of the per-region byte count

  localparam int PAT_SLOTS = 32;     // pattern bytes held in the registers
  localparam int IDX_W     = 5;      // index into the pattern bytes
  localparam int LEN_W     = 6;      // pattern_length register width
  localparam int CFG_W     = 64;     // widest register
  localparam int ADDR_W    = 64;
  localparam int PAT_CAP   = (MAX_PATTERN < PAT_SLOTS) ? MAX_PATTERN : PAT_SLOTS;
  localparam int WIN_DEPTH = MAX_PATTERN - 1;
  localparam int POS_W     = $clog2(MAX_PATTERN);
  localparam int CMP_W     = ((POS_W > LEN_W) ? POS_W : LEN_W) + 1;

  typedef enum logic [2:0] {
    REG_PAT_0_7   = 3'd0,
    REG_PAT_8_15  = 3'd1,
    REG_PAT_16_23 = 3'd2,
    REG_PAT_24_31 = 3'd3,
    REG_WILDCARD  = 3'd4,
    REG_PAT_LEN   = 3'd5,
    REG_BASE_ADDR = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       region_end;
  } in_beat_t;

  typedef struct packed {
    logic              match_found;
    logic [ADDR_W-1:0] match_address;
  } out_beat_t;

  // What every compare cell needs to see
  typedef struct packed {
    logic [PAT_SLOTS-1:0][7:0] pat;
    logic [PAT_SLOTS-1:0]      wild;
    logic [LEN_W-1:0]          len;   // already capped at PAT_CAP
  } match_cfg_t;

endpackage

// ===== design/mbps_cell.sv =====
// ----------------------------------------------------------------------------
// mbps_cell: one window stage
// Holds one past byte, passes it on each shift and checks it against the
// pattern byte that lines up with its distance from the current byte.
// ----------------------------------------------------------------------------
module mbps_cell
  import mbps_pkg::*;
(
  input  logic             clk,
  input  logic             shift,
  input  logic [7:0]       din,
  input  match_cfg_t       cfg,
  input  logic [POS_W-1:0] pos,    // cell k holds the byte k+1 back
  output logic [7:0]       held,
  output logic             ok
);

  logic [CMP_W-1:0] back;
  logic [CMP_W-1:0] len_x;
  logic [CMP_W-1:0] diff;
  logic [IDX_W-1:0] idx;
  logic             in_use;

  always_ff @(posedge clk) begin
    if (shift) begin
      held <= din;
    end
  end

  always_comb begin
    back   = CMP_W'(pos) + CMP_W'(1);
    len_x  = CMP_W'(cfg.len);
    in_use = back < len_x;
    diff   = len_x - back - CMP_W'(1);   // pattern byte len-1-back
    idx    = diff[IDX_W-1:0];
    ok     = !in_use || cfg.wild[idx] || (held == cfg.pat[idx]);
  end

endmodule

// ===== design/mbps_chain.sv =====
// ----------------------------------------------------------------------------
// mbps_chain: shift window built from a row of compare cells
// The current byte enters cell 0; the AND of all cell checks plus the
// current-byte check says whether the window ending now matches.
// ----------------------------------------------------------------------------
module mbps_chain
  import mbps_pkg::*;
(
  input  logic       clk,
  input  logic       shift,
  input  logic [7:0] cur,
  input  match_cfg_t cfg,
  output logic       all_ok
);

  logic [WIN_DEPTH:0][7:0]  link;
  logic [WIN_DEPTH-1:0]     cell_ok;
  logic [IDX_W-1:0]         cur_idx;
  logic                     cur_ok;

  assign link[0] = cur;

  for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_cell
    mbps_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .din   (link[k]),
      .cfg   (cfg),
      .pos   (POS_W'(k)),
      .held  (link[k+1]),
      .ok    (cell_ok[k])
    );
  end

  // newest byte lines up with the last pattern byte
  always_comb begin
    cur_idx = IDX_W'(cfg.len - LEN_W'(1));
    cur_ok  = cfg.wild[cur_idx] || (cur == cfg.pat[cur_idx]);
    all_ok  = cur_ok && (&cell_ok);
  end

endmodule

// ===== design/masked_byte_pattern_scanner_core.sv =====
// ----------------------------------------------------------------------------
// masked_byte_pattern_scanner_core: wildcard byte pattern search
// Scans a byte stream for a masked pattern and reports the first hit
// address on the final byte of each region.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one byte per beat, region_end set on the last byte.
//   out channel : one beat per region, sent after its last byte; match_found
//                 and base_address + offset of the first match (0 if none).
//   cfg port    : write-only registers, index 0..6 (pattern words, wildcard
//                 mask, pattern length, base address). Write between regions.
// Throughput: one byte per cycle, except while a final byte is held off (see Stall). The window is a row of 31
//   cells that shift each accepted byte and compare in parallel, so the
//   match for the byte just taken is known in the same cycle.
// Latency: the result beat is valid the cycle after the last byte is taken.
// Stall: the single output register holds a result while out_ready is low.
//   Ordinary bytes keep flowing past it; only a final byte is held off
//   (in_ready low) until the register drains, and it may enter in the
//   drain cycle itself.
// Reset: registers return to defaults (pattern length 1), the byte count and
//   hit state clear, no result is pending. The window bytes need no reset:
//   the count gate keeps stale bytes out of every compare.
// ----------------------------------------------------------------------------
module masked_byte_pattern_scanner_core
  import mbps_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_beat_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_beat_t           out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  // configuration registers
  logic [3:0][63:0]      pat_word;
  logic [PAT_SLOTS-1:0]  wildcard_bits;
  logic [LEN_W-1:0]      pattern_length;
  logic [ADDR_W-1:0]     base_address;

  // scan state
  logic [COUNT_BITS-1:0] bytes_seen;
  logic [COUNT_BITS-1:0] bytes_seen_next;
  logic                  hit_seen;
  logic                  hit_seen_next;
  logic [COUNT_BITS-1:0] hit_offset;
  logic [COUNT_BITS-1:0] hit_offset_next;
  logic                  out_valid_next;
  out_beat_t             out_data_next;

  match_cfg_t            mcfg;
  logic [LEN_W-1:0]      len_eff;
  logic                  accept;
  logic                  win_ok;
  logic                  sat;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [COUNT_BITS-1:0] len_cnt;
  logic                  new_hit;
  logic                  found;
  logic [COUNT_BITS-1:0] offset_fin;

  // over-long lengths are clipped to what the window can hold
  assign len_eff = (pattern_length > LEN_W'(PAT_CAP)) ? LEN_W'(PAT_CAP) : pattern_length;

  assign mcfg.pat  = pat_word;
  assign mcfg.wild = wildcard_bits;
  assign mcfg.len  = len_eff;

  // output register frees up in the same cycle it is drained; only a final
  // byte needs it, so other bytes pass a held result
  assign in_ready = !out_valid || out_ready || !in_data.region_end;
  assign accept   = in_valid && in_ready;

  mbps_chain u_chain (
    .clk    (clk),
    .shift  (accept),
    .cur    (in_data.data_byte),
    .cfg    (mcfg),
    .all_ok (win_ok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_word       <= '0;
      wildcard_bits  <= '0;
      pattern_length <= LEN_W'(1);
      base_address   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_PAT_0_7:   pat_word[0]    <= cfg_wdata;
        REG_PAT_8_15:  pat_word[1]    <= cfg_wdata;
        REG_PAT_16_23: pat_word[2]    <= cfg_wdata;
        REG_PAT_24_31: pat_word[3]    <= cfg_wdata;
        REG_WILDCARD:  wildcard_bits  <= cfg_wdata[PAT_SLOTS-1:0];
        REG_PAT_LEN:   pattern_length <= cfg_wdata[LEN_W-1:0];
        REG_BASE_ADDR: base_address   <= cfg_wdata;
        default: ;   // unmapped index, write dropped
      endcase
    end
  end

  // count, first-hit tracking and result formation
  always_comb begin
    sat     = &bytes_seen;   // saturated count: byte shifts in, no compare
    cnt_inc = bytes_seen + COUNT_BITS'(1);
    len_cnt = COUNT_BITS'(len_eff);
    new_hit = !sat && !hit_seen && (len_eff != '0) && (cnt_inc >= len_cnt) && win_ok;

    bytes_seen_next = bytes_seen;
    hit_seen_next   = hit_seen;
    hit_offset_next = hit_offset;

    offset_fin = new_hit ? (cnt_inc - len_cnt) : hit_offset;
    found      = hit_seen || new_hit;

    out_data_next.match_found   = found;
    out_data_next.match_address = found ? (base_address + ADDR_W'(offset_fin)) : '0;

    out_valid_next = out_valid && !out_ready;

    if (accept) begin
      if (in_data.region_end) begin
        // region closes: scan state back to its start values
        bytes_seen_next = '0;
        hit_seen_next   = 1'b0;
        hit_offset_next = '0;
        out_valid_next  = 1'b1;
      end else begin
        if (!sat) begin
          bytes_seen_next = cnt_inc;
        end
        if (new_hit) begin
          hit_seen_next   = 1'b1;
          hit_offset_next = offset_fin;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      hit_seen   <= 1'b0;
      hit_offset <= '0;
      out_valid  <= 1'b0;
    end else begin
      bytes_seen <= bytes_seen_next;
      hit_seen   <= hit_seen_next;
      hit_offset <= hit_offset_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.region_end) begin
      out_data <= out_data_next;
    end
  end

  // a final byte always leaves a result beat behind
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.region_end |=> out_valid)
    else $error("region end did not produce a result beat");

  // a miss never carries an address
  a_miss_zero_addr: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.match_found |-> out_data.match_address == '0)
    else $error("no-match result with nonzero address");

  // a recorded hit needs bytes counted in this region
  a_hit_has_count: assert property (@(posedge clk) disable iff (rst)
    hit_seen |-> bytes_seen != '0)
    else $error("hit recorded with empty byte count");

  // the first hit starts strictly before the current count
  a_hit_offset_bound: assert property (@(posedge clk) disable iff (rst)
    hit_seen |-> hit_offset < bytes_seen)
    else $error("hit offset beyond bytes seen");

endmodule
